FILE: sv/uotr_pkg.sv
// Shared types, constants and helper functions for the upper-only text recaser.
package uotr_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned PtrW      = $clog2(FifoDepth);
  localparam int unsigned CntW      = $clog2(FifoDepth + 1);

  localparam logic [ByteW-1:0] ChrPeriod   = 8'h2E;
  localparam logic [ByteW-1:0] ChrQuestion = 8'h3F;
  localparam logic [ByteW-1:0] ChrBang     = 8'h21;
  localparam logic [ByteW-1:0] ChrLowerI   = 8'h69;
  localparam logic [ByteW-1:0] ChrUpperI   = 8'h49;
  localparam logic [ByteW-1:0] CaseClrMask = 8'hDF;
  localparam logic [ByteW-1:0] CaseSetMask = 8'h20;

  typedef enum logic [2:0] {
    MATCH_NONE  = 3'b001,
    MATCH_PUNCT = 3'b010,
    MATCH_I     = 3'b100
  } match_state_t;

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             last;
  } out_entry_t;

  function automatic logic is_letter(input logic [ByteW-1:0] b);
    is_letter = ((b >= 8'h41) && (b <= 8'h5A)) || ((b >= 8'h61) && (b <= 8'h7A));
  endfunction

  function automatic logic is_sentence_end(input logic [ByteW-1:0] b);
    is_sentence_end = (b == ChrPeriod) || (b == ChrQuestion) || (b == ChrBang);
  endfunction

  function automatic logic in_punct_set(input logic [ByteW-1:0] b);
    logic hit;
    case (b) inside
      8'h20, 8'h21, 8'h22, 8'h27, 8'h28, 8'h29,
      8'h3B, 8'h3C, 8'h3E, 8'h3F, 8'h5B, 8'h5D,
      8'h2C, 8'h2D, 8'h2E, 8'h3A, 8'h7B, 8'h7D: hit = 1'b1;
      default:                                   hit = 1'b0;
    endcase
    in_punct_set = hit;
  endfunction

endpackage

FILE: sv/upper_only_text_recaser_top.sv
// Top level of the upper-only text recaser: recasing, pronoun fix and result queue.
// A byte is held until the next byte of its message is accepted, then enters the queue;
//   a final byte is queued right behind its predecessor, or alone if it has none.
// Throughput: one byte per cycle; a final byte queues two results (one if alone), the next
//   message's first byte none; in_ready drops only while the four-entry queue holds 3+.
// Reset: rst_n clears the queue and returns the recaser to start-of-message state.
module upper_only_text_recaser_top (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [uotr_pkg::ByteW-1:0] in_byte,
  input  logic                    in_last,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [uotr_pkg::ByteW-1:0] out_byte,
  output logic                    out_last
);
  import uotr_pkg::*;

  logic               ase_r, ase_nxt;
  match_state_t       pms_r, pms_nxt;
  logic [ByteW-1:0]   held_byte_r, held_byte_nxt;
  logic               held_valid_r, held_valid_nxt;

  out_entry_t         fifo_r [FifoDepth];
  logic [PtrW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]    cnt_r, cnt_nxt;

  logic               in_acc, out_acc;
  logic               letter;
  logic [ByteW-1:0]   rec_byte;
  logic               fix_i;
  logic [ByteW-1:0]   held_out;
  logic [1:0]         push_cnt;
  logic [PtrW-1:0]    cur_slot;

  assign in_ready  = (cnt_r <= CntW'(FifoDepth - 2));
  assign in_acc    = in_valid && in_ready;
  assign out_valid = (cnt_r != '0);
  assign out_acc   = out_valid && out_ready;
  assign out_byte  = fifo_r[rd_ptr_r].data;
  assign out_last  = fifo_r[rd_ptr_r].last;

  always_comb begin
    letter = is_letter(in_byte);
    if (!letter) begin
      rec_byte = in_byte;
    end else if (ase_r) begin
      rec_byte = in_byte & CaseClrMask;
    end else begin
      rec_byte = in_byte | CaseSetMask;
    end

    if (is_sentence_end(in_byte)) begin
      ase_nxt = 1'b1;
    end else if (letter) begin
      ase_nxt = 1'b0;
    end else begin
      ase_nxt = ase_r;
    end

    fix_i = 1'b0;
    unique case (pms_r)
      MATCH_PUNCT: begin
        pms_nxt = (rec_byte == ChrLowerI) ? MATCH_I : MATCH_NONE;
      end
      MATCH_I: begin
        fix_i   = !is_letter(rec_byte) && held_valid_r;
        pms_nxt = in_punct_set(rec_byte) ? MATCH_PUNCT : MATCH_NONE;
      end
      default: begin
        pms_nxt = in_punct_set(rec_byte) ? MATCH_PUNCT : MATCH_NONE;
      end
    endcase
    held_out = fix_i ? ChrUpperI : held_byte_r;

    if (in_last) begin
      ase_nxt        = 1'b1;
      pms_nxt        = MATCH_NONE;
      held_byte_nxt  = '0;
      held_valid_nxt = 1'b0;
    end else begin
      held_byte_nxt  = rec_byte;
      held_valid_nxt = 1'b1;
    end

    push_cnt   = in_acc ? ({1'b0, held_valid_r} + {1'b0, in_last}) : 2'd0;
    cur_slot   = held_valid_r ? PtrW'(wr_ptr_r + 1'b1) : wr_ptr_r;
    wr_ptr_nxt = PtrW'(wr_ptr_r + PtrW'(push_cnt));
    rd_ptr_nxt = out_acc ? PtrW'(rd_ptr_r + 1'b1) : rd_ptr_r;
    cnt_nxt    = CntW'(cnt_r + CntW'(push_cnt) - CntW'(out_acc));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ase_r        <= 1'b1;
      pms_r        <= MATCH_NONE;
      held_byte_r  <= '0;
      held_valid_r <= 1'b0;
      wr_ptr_r     <= '0;
      rd_ptr_r     <= '0;
      cnt_r        <= '0;
    end else begin
      if (in_acc) begin
        ase_r        <= ase_nxt;
        pms_r        <= pms_nxt;
        held_byte_r  <= held_byte_nxt;
        held_valid_r <= held_valid_nxt;
      end
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      if (held_valid_r) begin
        fifo_r[wr_ptr_r] <= '{data: held_out, last: 1'b0};
      end
      if (in_last) begin
        fifo_r[cur_slot] <= '{data: rec_byte, last: 1'b1};
      end
    end
  end

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CntW'(FifoDepth))
    else $error("result queue overflow");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_last) |=> (!held_valid_r && ase_r && (pms_r == MATCH_NONE)))
    else $error("recaser state not cleared after last request");

  a_held_after_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !in_last) |=> held_valid_r)
    else $error("byte not held after non-final request");

  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && held_valid_r && in_last && !out_acc) |=> (cnt_r == $past(cnt_r) + 2'd2))
    else $error("final request did not queue two results");
`endif

endmodule
